/* design/fdet_pkg.sv */
// Shared types, constants and format helpers for the 3x3 floating-point determinant.
package fdet_pkg;

  localparam int EW = 13;
  localparam int SW = 53;
  localparam int MW = 106;
  localparam int LO = 27;
  localparam int AW = 56;
  localparam int NG = 14;
  localparam int PW = NG * 8;
  localparam int P32 = 24;
  localparam int PAD32 = SW - P32;
  localparam int RND_LAT = 5;
  localparam int MUL_LAT = 2 + RND_LAT;
  localparam int ADD_LAT = 3 + RND_LAT;

  localparam logic signed [EW-1:0] EMIN32 = -13'sd126;
  localparam logic signed [EW-1:0] EMAX32 = 13'sd127;
  localparam logic signed [EW-1:0] EMIN64 = -13'sd1022;
  localparam logic signed [EW-1:0] EMAX64 = 13'sd1023;
  localparam logic signed [EW-1:0] MW_S = EW'(MW);
  localparam logic signed [EW-1:0] AW_S = EW'(AW);

  localparam logic [63:0] NAN64 = 64'h7FF8_0000_0000_0000;
  localparam logic [63:0] NAN32 = 64'h0000_0000_7FC0_0000;

  typedef struct packed {
    logic                 nan;
    logic                 inf;
    logic                 sign;
    logic signed [EW-1:0] exp;
    logic [SW-1:0]        sig;
  } fp_t;

  typedef struct packed {
    logic func;
    logic nan;
    logic inf;
    logic sign;
  } side_t;

  typedef struct packed {
    side_t                sd;
    logic signed [EW-1:0] etop;
    logic [MW-1:0]        mag;
  } raw_t;

  function automatic logic signed [EW-1:0] emin(input logic func);
    return func ? EMIN64 : EMIN32;
  endfunction

  function automatic logic signed [EW-1:0] emax(input logic func);
    return func ? EMAX64 : EMAX32;
  endfunction

  function automatic fp_t unpack(input logic func, input logic [63:0] bits);
    fp_t        r;
    logic [10:0] e64;
    logic [7:0]  e32;
    e64 = bits[62:52];
    e32 = bits[30:23];
    if (func) begin
      r.sign = bits[63];
      r.nan  = (e64 == 11'h7FF) && (bits[51:0] != 52'd0);
      r.inf  = (e64 == 11'h7FF) && (bits[51:0] == 52'd0);
      r.exp  = (e64 == 11'd0) ? EMIN64 : ($signed({2'b00, e64}) - 13'sd1023);
      r.sig  = {(e64 != 11'd0), bits[51:0]};
    end else begin
      r.sign = bits[31];
      r.nan  = (e32 == 8'hFF) && (bits[22:0] != 23'd0);
      r.inf  = (e32 == 8'hFF) && (bits[22:0] == 23'd0);
      r.exp  = (e32 == 8'd0) ? EMIN32 : ($signed({5'b00000, e32}) - 13'sd127);
      r.sig  = {(e32 != 8'd0), bits[22:0], {PAD32{1'b0}}};
    end
    return r;
  endfunction

  function automatic logic [63:0] pack(input logic func, input fp_t x);
    logic [EW-1:0] t64;
    logic [EW-1:0] t32;
    logic [10:0]   be64;
    logic [7:0]    be32;
    logic [63:0]   r;
    t64  = x.exp + 13'sd1023;
    t32  = x.exp + 13'sd127;
    be64 = x.sig[SW-1] ? t64[10:0] : 11'd0;
    be32 = x.sig[SW-1] ? t32[7:0] : 8'd0;
    if (x.nan) begin
      r = func ? NAN64 : NAN32;
    end else if (x.inf) begin
      r = func ? {x.sign, 11'h7FF, 52'd0} : {32'd0, x.sign, 8'hFF, 23'd0};
    end else begin
      r = func ? {x.sign, be64, x.sig[51:0]} : {32'd0, x.sign, be32, x.sig[51:PAD32]};
    end
    return r;
  endfunction

  function automatic logic [2:0] lzc8(input logic [7:0] v);
    logic [2:0] r;
    r = 3'd0;
    for (int i = 0; i < 8; i++) begin
      if (v[i]) begin
        r = 3'(7 - i);
      end
    end
    return r;
  endfunction

endpackage

/* design/float_determinant_3x3.sv */
// Top level of the pipelined 3x3 floating-point determinant by cofactor expansion.
//
//   Channel   Valid         Stall          Payload
//   input     valid         stall          func, a1, a2, a3, b1, b2, b3, c1, c2, c3
//   output    result_valid  result_stall   determinant
//
// One transfer is accepted per cycle while stall is low.
// A result passes through the chain unpack, multiply, subtract, multiply, subtract, add.
// Reset is synchronous and clears only the valid bits and the skid-full flag.
// When the output stalls, one more result is caught in a skid register; then the whole
// pipeline holds and stall is raised on the input side until the skid register empties.
module float_determinant_3x3 (
  input  logic        clk,
  input  logic        rst,
  input  logic        valid,
  output logic        stall,
  input  logic        func,
  input  logic [63:0] a1,
  input  logic [63:0] a2,
  input  logic [63:0] a3,
  input  logic [63:0] b1,
  input  logic [63:0] b2,
  input  logic [63:0] b3,
  input  logic [63:0] c1,
  input  logic [63:0] c2,
  input  logic [63:0] c3,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [63:0] determinant
);

  localparam int LAT = 1 + 2 * fdet_pkg::MUL_LAT + 3 * fdet_pkg::ADD_LAT;
  localparam int D1 = fdet_pkg::MUL_LAT + fdet_pkg::ADD_LAT;
  localparam int D2 = fdet_pkg::ADD_LAT;

  logic             en;
  logic [LAT-1:0]   vld;
  logic             skid_full;
  logic [63:0]      skid;
  logic [63:0]      packed_res;

  logic             func0;
  fdet_pkg::fp_t    ua1, ua2, ua3, ub1, ub2, ub3, uc1, uc2, uc3;
  fdet_pkg::fp_t    dl_a1 [D1];
  fdet_pkg::fp_t    dl_b1 [D1];
  fdet_pkg::fp_t    dl_c1 [D1];
  fdet_pkg::fp_t    dl_p3 [D2];

  fdet_pkg::fp_t    b2c3, b3c2, a2c3, a3c2, a2b3, a3b2;
  fdet_pkg::fp_t    m1, m2, m3, p1, p2, p3, q, r;
  logic             f1, f2, f3, f4, f5;
  logic             f1_b, f1_c, f1_d, f1_e, f1_f, f2_b, f2_c, f3_b, f3_c;

  assign en         = !skid_full;
  assign stall      = skid_full;
  assign packed_res = fdet_pkg::pack(f5, r);

  always_ff @(posedge clk) begin
    if (en) begin
      func0 <= func;
      ua1   <= fdet_pkg::unpack(func, a1);
      ua2   <= fdet_pkg::unpack(func, a2);
      ua3   <= fdet_pkg::unpack(func, a3);
      ub1   <= fdet_pkg::unpack(func, b1);
      ub2   <= fdet_pkg::unpack(func, b2);
      ub3   <= fdet_pkg::unpack(func, b3);
      uc1   <= fdet_pkg::unpack(func, c1);
      uc2   <= fdet_pkg::unpack(func, c2);
      uc3   <= fdet_pkg::unpack(func, c3);
      dl_a1[0] <= ua1;
      dl_b1[0] <= ub1;
      dl_c1[0] <= uc1;
      for (int i = 1; i < D1; i++) begin
        dl_a1[i] <= dl_a1[i-1];
        dl_b1[i] <= dl_b1[i-1];
        dl_c1[i] <= dl_c1[i-1];
      end
      dl_p3[0] <= p3;
      for (int i = 1; i < D2; i++) begin
        dl_p3[i] <= dl_p3[i-1];
      end
    end
  end

  fdet_fmul u_mul_b2c3 (.clk(clk), .en(en), .func_in(func0), .a(ub2), .b(uc3),
                        .y(b2c3), .func_out(f1));
  fdet_fmul u_mul_b3c2 (.clk(clk), .en(en), .func_in(func0), .a(ub3), .b(uc2),
                        .y(b3c2), .func_out(f1_b));
  fdet_fmul u_mul_a2c3 (.clk(clk), .en(en), .func_in(func0), .a(ua2), .b(uc3),
                        .y(a2c3), .func_out(f1_c));
  fdet_fmul u_mul_a3c2 (.clk(clk), .en(en), .func_in(func0), .a(ua3), .b(uc2),
                        .y(a3c2), .func_out(f1_d));
  fdet_fmul u_mul_a2b3 (.clk(clk), .en(en), .func_in(func0), .a(ua2), .b(ub3),
                        .y(a2b3), .func_out(f1_e));
  fdet_fmul u_mul_a3b2 (.clk(clk), .en(en), .func_in(func0), .a(ua3), .b(ub2),
                        .y(a3b2), .func_out(f1_f));

  fdet_fadd u_sub_m1 (.clk(clk), .en(en), .func_in(f1), .sub(1'b1), .a(b2c3), .b(b3c2),
                      .y(m1), .func_out(f2));
  fdet_fadd u_sub_m2 (.clk(clk), .en(en), .func_in(f1), .sub(1'b1), .a(a2c3), .b(a3c2),
                      .y(m2), .func_out(f2_b));
  fdet_fadd u_sub_m3 (.clk(clk), .en(en), .func_in(f1), .sub(1'b1), .a(a2b3), .b(a3b2),
                      .y(m3), .func_out(f2_c));

  fdet_fmul u_mul_p1 (.clk(clk), .en(en), .func_in(f2), .a(dl_a1[D1-1]), .b(m1),
                      .y(p1), .func_out(f3));
  fdet_fmul u_mul_p2 (.clk(clk), .en(en), .func_in(f2), .a(dl_b1[D1-1]), .b(m2),
                      .y(p2), .func_out(f3_b));
  fdet_fmul u_mul_p3 (.clk(clk), .en(en), .func_in(f2), .a(dl_c1[D1-1]), .b(m3),
                      .y(p3), .func_out(f3_c));

  fdet_fadd u_sub_q (.clk(clk), .en(en), .func_in(f3), .sub(1'b1), .a(p1), .b(p2),
                     .y(q), .func_out(f4));
  fdet_fadd u_add_r (.clk(clk), .en(en), .func_in(f4), .sub(1'b0), .a(q), .b(dl_p3[D2-1]),
                     .y(r), .func_out(f5));

  always_ff @(posedge clk) begin
    if (rst) begin
      vld          <= '0;
      result_valid <= 1'b0;
      skid_full    <= 1'b0;
    end else begin
      if (en) begin
        vld <= {vld[LAT-2:0], valid};
        if (result_valid && result_stall) begin
          if (vld[LAT-1]) begin
            skid_full <= 1'b1;
          end
        end else begin
          result_valid <= vld[LAT-1];
        end
      end else if (!result_stall) begin
        skid_full <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (result_valid && result_stall) begin
        skid <= packed_res;
      end else begin
        determinant <= packed_res;
      end
    end else if (!result_stall) begin
      determinant <= skid;
    end
  end

endmodule

/* design/fdet_round.sv */
// Normalize, denormalize and round-to-nearest-even back end shared by the arithmetic units.
module fdet_round (
  input  logic            clk,
  input  logic            en,
  input  fdet_pkg::raw_t  x,
  output fdet_pkg::fp_t   y,
  output logic            func_out
);

  fdet_pkg::side_t                   s1_sd, s2_sd, s3_sd, s4_sd;
  logic signed [fdet_pkg::EW-1:0]    s1_etop, s2_etop, s3_er, s4_er;
  logic [fdet_pkg::MW-1:0]           s1_mag, s2_mag, s3_mag, s4_m;
  logic [fdet_pkg::NG-1:0]           s1_nz;
  logic [fdet_pkg::NG-1:0][2:0]      s1_glz;
  logic [6:0]                        s2_lz, s3_amt;
  logic                              s3_left, s4_st;

  logic [fdet_pkg::PW-1:0]           padded;
  logic [fdet_pkg::NG-1:0]           nz;
  logic [fdet_pkg::NG-1:0][2:0]      glz;
  logic [6:0]                        lz;
  logic signed [fdet_pkg::EW-1:0]    e_norm, em, sh, rsh, er;
  logic [6:0]                        amt;
  logic                              left;
  logic [fdet_pkg::MW-1:0]           m;
  logic                              st;
  logic [fdet_pkg::SW-1:0]           kept;
  logic                              g, sb, lsb, inc;
  logic [fdet_pkg::SW:0]             inc_v, sum;
  logic [fdet_pkg::SW-1:0]           sig;
  logic signed [fdet_pkg::EW-1:0]    e_out;
  fdet_pkg::fp_t                     y_next;

  always_comb begin
    padded = {x.mag, {(fdet_pkg::PW - fdet_pkg::MW){1'b1}}};
    for (int i = 0; i < fdet_pkg::NG; i++) begin
      nz[i]  = |padded[fdet_pkg::PW-1-8*i -: 8];
      glz[i] = fdet_pkg::lzc8(padded[fdet_pkg::PW-1-8*i -: 8]);
    end
  end

  always_comb begin
    lz = 7'd0;
    for (int i = fdet_pkg::NG - 1; i >= 0; i--) begin
      if (s1_nz[i]) begin
        lz = {4'(i), s1_glz[i]};
      end
    end
  end

  always_comb begin
    em     = fdet_pkg::emin(s2_sd.func);
    e_norm = s2_etop - $signed({6'b000000, s2_lz});
    sh     = s2_etop - em;
    rsh    = -sh;
    if (e_norm >= em) begin
      left = 1'b1;
      amt  = s2_lz;
      er   = e_norm;
    end else if (sh >= 0) begin
      left = 1'b1;
      amt  = sh[6:0];
      er   = em;
    end else begin
      left = 1'b0;
      amt  = (rsh >= fdet_pkg::MW_S) ? 7'(fdet_pkg::MW) : rsh[6:0];
      er   = em;
    end
  end

  always_comb begin
    if (s3_left) begin
      m  = s3_mag << s3_amt;
      st = 1'b0;
    end else begin
      m  = s3_mag >> s3_amt;
      st = |(s3_mag << (7'(fdet_pkg::MW) - s3_amt));
    end
  end

  always_comb begin
    if (s4_sd.func) begin
      kept = s4_m[fdet_pkg::MW-1 -: fdet_pkg::SW];
      g    = s4_m[fdet_pkg::MW-fdet_pkg::SW-1];
      sb   = |s4_m[fdet_pkg::MW-fdet_pkg::SW-2:0];
      lsb  = s4_m[fdet_pkg::MW-fdet_pkg::SW];
      inc_v = (fdet_pkg::SW+1)'(1);
    end else begin
      kept = {s4_m[fdet_pkg::MW-1 -: fdet_pkg::P32], {fdet_pkg::PAD32{1'b0}}};
      g    = s4_m[fdet_pkg::MW-fdet_pkg::P32-1];
      sb   = |s4_m[fdet_pkg::MW-fdet_pkg::P32-2:0];
      lsb  = s4_m[fdet_pkg::MW-fdet_pkg::P32];
      inc_v = (fdet_pkg::SW+1)'(1) << fdet_pkg::PAD32;
    end
    inc = g && (sb || s4_st || lsb);
    sum = {1'b0, kept} + (inc ? inc_v : '0);
    if (sum[fdet_pkg::SW]) begin
      sig   = sum[fdet_pkg::SW:1];
      e_out = s4_er + 13'sd1;
    end else begin
      sig   = sum[fdet_pkg::SW-1:0];
      e_out = s4_er;
    end
    y_next.nan  = s4_sd.nan;
    y_next.sign = s4_sd.sign;
    y_next.inf  = 1'b0;
    y_next.exp  = e_out;
    y_next.sig  = sig;
    if (s4_sd.nan) begin
      y_next.exp = fdet_pkg::emin(s4_sd.func);
      y_next.sig = '0;
    end else if (s4_sd.inf || (sig != '0 && e_out > fdet_pkg::emax(s4_sd.func))) begin
      y_next.inf = 1'b1;
      y_next.exp = fdet_pkg::emin(s4_sd.func);
      y_next.sig = '0;
    end else if (sig == '0) begin
      y_next.exp = fdet_pkg::emin(s4_sd.func);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_sd    <= x.sd;
      s1_etop  <= x.etop;
      s1_mag   <= x.mag;
      s1_nz    <= nz;
      s1_glz   <= glz;
      s2_sd    <= s1_sd;
      s2_etop  <= s1_etop;
      s2_mag   <= s1_mag;
      s2_lz    <= lz;
      s3_sd    <= s2_sd;
      s3_mag   <= s2_mag;
      s3_left  <= left;
      s3_amt   <= amt;
      s3_er    <= er;
      s4_sd    <= s3_sd;
      s4_m     <= m;
      s4_st    <= st;
      s4_er    <= s3_er;
      y        <= y_next;
      func_out <= s4_sd.func;
    end
  end

endmodule

/* design/fdet_fmul.sv */
// Pipelined floating-point multiplier with split partial products.
module fdet_fmul (
  input  logic           clk,
  input  logic           en,
  input  logic           func_in,
  input  fdet_pkg::fp_t  a,
  input  fdet_pkg::fp_t  b,
  output fdet_pkg::fp_t  y,
  output logic           func_out
);

  localparam int HW = fdet_pkg::SW - fdet_pkg::LO;

  fdet_pkg::side_t                  m1_sd, sd;
  logic signed [fdet_pkg::EW-1:0]   m1_etop;
  logic [2*HW-1:0]                  pp_hh;
  logic [HW+fdet_pkg::LO-1:0]       pp_hl, pp_lh;
  logic [2*fdet_pkg::LO-1:0]        pp_ll;
  fdet_pkg::raw_t                   m2;
  logic                             az, bz;

  always_comb begin
    az      = !a.nan && !a.inf && (a.sig == '0);
    bz      = !b.nan && !b.inf && (b.sig == '0);
    sd.func = func_in;
    sd.nan  = a.nan || b.nan || (a.inf && bz) || (b.inf && az);
    sd.inf  = a.inf || b.inf;
    sd.sign = a.sign ^ b.sign;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m1_sd   <= sd;
      m1_etop <= a.exp + b.exp + 13'sd1;
      pp_hh   <= a.sig[fdet_pkg::SW-1:fdet_pkg::LO] * b.sig[fdet_pkg::SW-1:fdet_pkg::LO];
      pp_hl   <= a.sig[fdet_pkg::SW-1:fdet_pkg::LO] * b.sig[fdet_pkg::LO-1:0];
      pp_lh   <= a.sig[fdet_pkg::LO-1:0] * b.sig[fdet_pkg::SW-1:fdet_pkg::LO];
      pp_ll   <= a.sig[fdet_pkg::LO-1:0] * b.sig[fdet_pkg::LO-1:0];
      m2.sd   <= m1_sd;
      m2.etop <= m1_etop;
      m2.mag  <= (fdet_pkg::MW'(pp_hh) << (2 * fdet_pkg::LO))
               + ((fdet_pkg::MW'(pp_hl) + fdet_pkg::MW'(pp_lh)) << fdet_pkg::LO)
               + fdet_pkg::MW'(pp_ll);
    end
  end

  fdet_round u_round (
    .clk      (clk),
    .en       (en),
    .x        (m2),
    .y        (y),
    .func_out (func_out)
  );

endmodule

/* design/fdet_fadd.sv */
// Pipelined floating-point adder and subtractor.
module fdet_fadd (
  input  logic           clk,
  input  logic           en,
  input  logic           func_in,
  input  logic           sub,
  input  fdet_pkg::fp_t  a,
  input  fdet_pkg::fp_t  b,
  output fdet_pkg::fp_t  y,
  output logic           func_out
);

  fdet_pkg::side_t                 sd, a1_sd, a2_sd;
  logic                            sbe, a_ge, eq, eff_sub;
  fdet_pkg::fp_t                   lg, sm;
  logic signed [fdet_pkg::EW-1:0]  diff;
  logic [5:0]                      shamt;
  logic                            a1_sub, a2_sub;
  logic signed [fdet_pkg::EW-1:0]  a1_lexp, a2_lexp;
  logic [fdet_pkg::SW-1:0]         a1_lsig, a1_ssig;
  logic [5:0]                      a1_shamt;
  logic [fdet_pkg::AW-1:0]         sx, sj, a2_lw, a2_sw;
  logic [fdet_pkg::AW:0]           sum;
  fdet_pkg::raw_t                  a3;

  always_comb begin
    sbe  = b.sign ^ sub;
    a_ge = (a.exp > b.exp) || ((a.exp == b.exp) && (a.sig >= b.sig));
    eq   = (a.exp == b.exp) && (a.sig == b.sig);
    lg   = a_ge ? a : b;
    sm   = a_ge ? b : a;
    eff_sub = a.sign ^ sbe;
    diff = lg.exp - sm.exp;
    shamt = (diff > fdet_pkg::AW_S) ? 6'(fdet_pkg::AW) : diff[5:0];
    sd.func = func_in;
    sd.nan  = a.nan || b.nan || (a.inf && b.inf && eff_sub);
    sd.inf  = a.inf || b.inf;
    if (sd.inf) begin
      sd.sign = a.inf ? a.sign : sbe;
    end else if (eq && eff_sub) begin
      sd.sign = 1'b0;
    end else begin
      sd.sign = a_ge ? a.sign : sbe;
    end
  end

  always_comb begin
    sx = {a1_ssig, 3'b000};
    sj = (sx >> a1_shamt) | fdet_pkg::AW'(|(sx << (6'(fdet_pkg::AW) - a1_shamt)));
    if (a2_sub) begin
      sum = {1'b0, a2_lw} - {1'b0, a2_sw};
    end else begin
      sum = {1'b0, a2_lw} + {1'b0, a2_sw};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a1_sd    <= sd;
      a1_sub   <= eff_sub;
      a1_lexp  <= lg.exp;
      a1_lsig  <= lg.sig;
      a1_ssig  <= sm.sig;
      a1_shamt <= shamt;
      a2_sd    <= a1_sd;
      a2_sub   <= a1_sub;
      a2_lexp  <= a1_lexp;
      a2_lw    <= {a1_lsig, 3'b000};
      a2_sw    <= sj;
      a3.sd    <= a2_sd;
      a3.etop  <= a2_lexp + 13'sd1;
      a3.mag   <= {sum, {(fdet_pkg::MW - fdet_pkg::AW - 1){1'b0}}};
    end
  end

  fdet_round u_round (
    .clk      (clk),
    .en       (en),
    .x        (a3),
    .y        (y),
    .func_out (func_out)
  );

endmodule
